FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros shared by the frame checker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/rcfc_pkg.sv
// ----------------------------------------------------------------------------
// rcfc_pkg
// Shared types, constants and helpers of the response frame checker.
// ----------------------------------------------------------------------------
package rcfc_pkg;

    localparam int MAX_FRAME_DEFAULT = 64;

    localparam logic [7:0] CHAR_SEMI = 8'h3B;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [15:0] PFX_FA = 16'h4146;
    localparam logic [15:0] PFX_FB = 16'h4246;
    localparam logic [15:0] PFX_MD = 16'h444D;
    localparam logic [15:0] PFX_TQ = 16'h5154;

    // character positions (0 based) holding the frequency digits
    localparam logic [6:0] DIGIT_FIRST_POS = 7'd2;
    localparam logic [6:0] DIGIT_LAST_POS  = 7'd12;
    // position of ';' in a complete FA/FB frame and in an MD/TQ frame
    localparam logic [6:0] FREQ_SEMI_POS   = 7'd13;
    localparam logic [6:0] SHORT_SEMI_POS  = 7'd3;
    localparam logic [6:0] ARG_POS         = 7'd2;

    localparam logic [23:0] PREFIX_RESET     = 24'h004146;
    localparam logic [1:0]  PREFIX_LEN_RESET = 2'd2;

    typedef enum logic [0:0] {
        REG_EXPECTED_PREFIX = 1'b0,
        REG_PREFIX_LENGTH   = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [23:0] expected_prefix;
        logic [1:0]  prefix_length;
    } cfg_t;

    typedef struct packed {
        logic        valid_res;
        logic [36:0] frequency_hz;
        logic [3:0]  mode_number;
        logic        transmitting;
        logic [6:0]  frame_length;
        logic        too_long;
    } result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic [7:0] prefix_byte(input logic [23:0] pfx,
                                               input logic [1:0]  idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = pfx[7:0];
            2'd1:    b = pfx[15:8];
            2'd2:    b = pfx[23:16];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/cat_response_frame_checker_top.sv
// ----------------------------------------------------------------------------
// cat_response_frame_checker_top
// Semicolon-terminated response frame checker, one byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries one received byte per transfer (s_character).
//   Every ';' closes a frame and yields one result transfer on m_*;
//   other bytes only update the frame state and produce nothing.
//   cfg_wr_en/cfg_addr/cfg_wdata write expected_prefix (addr 0) and
//   prefix_length (addr 1); write only while no frame result is pending.
// Timing:
//   One byte accepted per clock while s_ready is high. The result of a ';' is
//   evaluated combinationally from the frame state registers and registered in
//   the result register (or the skid entry), which drives m_valid. Per-byte work
//   is a single pass of compare and a x10 shift-add into the frame state registers.
// Reset (aresetn low, synchronous): frame state cleared, prefix "FA",
//   prefix length 2, no result pending.
// Stall: a result register plus one skid entry hold results while m_ready
//   is low; s_ready drops only once both are full.
// ----------------------------------------------------------------------------
module cat_response_frame_checker_top
    import rcfc_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_character,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_valid_res,
    output logic [36:0] m_frequency_hz,
    output logic [3:0]  m_mode_number,
    output logic        m_transmitting,
    output logic [6:0]  m_frame_length,
    output logic        m_too_long,

    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_addr,
    input  logic [23:0] cfg_wdata
);

    cfg_t    cfg_reg, cfg_next;
    logic    accept;
    logic    res_fire;
    result_t res;
    result_t out_data;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_EXPECTED_PREFIX: cfg_next.expected_prefix = cfg_wdata;
                REG_PREFIX_LENGTH:   cfg_next.prefix_length   = cfg_wdata[1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_prefix <= PREFIX_RESET;
            cfg_reg.prefix_length   <= PREFIX_LEN_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign accept = s_valid && s_ready;

    rcfc_frame #(
        .MAX_FRAME (MAX_FRAME)
    ) u_frame (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .character (s_character),
        .cfg       (cfg_reg),
        .res_fire  (res_fire),
        .res       (res)
    );

    rcfc_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_fire),
        .push_data (res),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_valid_res    = out_data.valid_res;
    assign m_frequency_hz = out_data.frequency_hz;
    assign m_mode_number  = out_data.mode_number;
    assign m_transmitting = out_data.transmitting;
    assign m_frame_length = out_data.frame_length;
    assign m_too_long     = out_data.too_long;

endmodule

FILE: rtl/rcfc_frame.sv
// ----------------------------------------------------------------------------
// rcfc_frame
// Per-frame tracking state and the end-of-frame rule evaluation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rcfc_frame
    import rcfc_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] character,
    input  cfg_t       cfg,
    output logic       res_fire,
    output result_t    res
);

    localparam logic [6:0] MAX_POS = 7'(MAX_FRAME);

    logic [6:0]  pos_reg,   pos_next;
    logic        match_reg, match_next;
    logic        dec_reg,   dec_next;
    logic [36:0] acc_reg,   acc_next;
    logic [7:0]  arg_reg,   arg_next;
    logic        ovf_reg,   ovf_next;

    logic        is_semi;
    logic [6:0]  plen;
    logic [15:0] pfx2;
    logic        two;
    logic        too_long;
    logic        matched;

    assign is_semi  = (character == CHAR_SEMI);
    assign res_fire = accept && is_semi;
    assign plen     = {5'd0, cfg.prefix_length};
    assign pfx2     = cfg.expected_prefix[15:0];
    assign two      = (cfg.prefix_length == 2'd2);
    assign too_long = (pos_reg == MAX_POS);
    assign matched  = !too_long && match_reg && (pos_reg >= plen);

    always_comb begin
        pos_next   = pos_reg;
        match_next = match_reg;
        dec_next   = dec_reg;
        acc_next   = acc_reg;
        arg_next   = arg_reg;
        ovf_next   = ovf_reg;
        if (accept) begin
            if (is_semi) begin
                pos_next   = '0;
                match_next = 1'b1;
                dec_next   = 1'b1;
                acc_next   = '0;
                arg_next   = '0;
                ovf_next   = 1'b0;
            end else if (pos_reg == MAX_POS) begin
                ovf_next = 1'b1;
            end else begin
                if (pos_reg < plen &&
                    character != prefix_byte(cfg.expected_prefix, pos_reg[1:0])) begin
                    match_next = 1'b0;
                end
                if (pos_reg == ARG_POS) begin
                    arg_next = character;
                end
                if (pos_reg >= DIGIT_FIRST_POS && pos_reg <= DIGIT_LAST_POS) begin
                    if (is_digit(character)) begin
                        acc_next = (acc_reg << 3) + (acc_reg << 1) + {33'd0, character[3:0]};
                    end else begin
                        dec_next = 1'b0;
                    end
                end
                pos_next = pos_reg + 7'd1;
                if (pos_next == MAX_POS) begin
                    ovf_next = 1'b1;
                end
            end
        end
    end

    always_comb begin
        res              = '0;
        res.too_long     = too_long;
        res.frame_length = too_long ? MAX_POS : pos_reg + 7'd1;
        if (matched) begin
            if (two && (pfx2 == PFX_FA || pfx2 == PFX_FB)) begin
                res.valid_res = (pos_reg == FREQ_SEMI_POS) && dec_reg;
                if (res.valid_res) begin
                    res.frequency_hz = acc_reg;
                end
            end else if (two && pfx2 == PFX_MD) begin
                res.valid_res = (pos_reg == SHORT_SEMI_POS) &&
                                arg_reg >= CHAR_ONE && arg_reg <= CHAR_NINE;
                if (res.valid_res) begin
                    res.mode_number = arg_reg[3:0];
                end
            end else if (two && pfx2 == PFX_TQ) begin
                res.valid_res = (pos_reg == SHORT_SEMI_POS) &&
                                (arg_reg == CHAR_ZERO || arg_reg == CHAR_ONE);
                if (res.valid_res) begin
                    res.transmitting = (arg_reg == CHAR_ONE);
                end
            end else begin
                res.valid_res = (pos_reg > plen);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            match_reg <= 1'b1;
            dec_reg   <= 1'b1;
            acc_reg   <= '0;
            arg_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            match_reg <= match_next;
            dec_reg   <= dec_next;
            acc_reg   <= acc_next;
            arg_reg   <= arg_next;
            ovf_reg   <= ovf_next;
        end
    end

    // overflow flag tracks the saturated position
    `ASSERT_ALWAYS(a_pos_range, aclk, aresetn, pos_reg <= MAX_POS)
    `ASSERT_ALWAYS(a_ovf_pos, aclk, aresetn, ovf_reg == (pos_reg == MAX_POS))
    `ASSERT_NEXT(a_semi_clears, aclk, aresetn, res_fire, pos_reg == 7'd0 && match_reg)
    `ASSERT_ALWAYS(a_long_invalid, aclk, aresetn, !(too_long && res.valid_res))

endmodule

FILE: rtl/rcfc_out_buf.sv
// ----------------------------------------------------------------------------
// rcfc_out_buf
// Result output register with a skid stage; drives the input ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rcfc_out_buf
    import rcfc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg,  out_valid_next;
    result_t out_data_reg,   out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg,  skid_data_next;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `ASSERT_ALWAYS(a_skid_behind_out, aclk, aresetn, !skid_valid_reg || out_valid_reg)
    `ASSERT_ALWAYS(a_no_push_full, aclk, aresetn, !(push && skid_valid_reg))
    `ASSERT_NEXT(a_skid_drain, aclk, aresetn, skid_valid_reg && out_ready, !skid_valid_reg)

endmodule

FILE: tb/cat_response_frame_checker_top_tb.sv
// ----------------------------------------------------------------------------
// cat_response_frame_checker_top_tb
// Streams response bytes through the frame checker and checks every frame
// verdict against a cycle-free prediction of prefix match, per-prefix rule,
// decoded frequency, mode, transmit state and frame length. A directed
// opener covers the recognized prefixes, the empty prefix, a register write
// mid-frame and an overlong frame; then phases of random frames run under
// several prefix settings with random idling on both channels.
// ----------------------------------------------------------------------------
import rcfc_pkg::*;

class frame_verdicts;
    localparam int FRAME_LIMIT = MAX_FRAME_DEFAULT;
    localparam int FREQ_FRAME_LEN = 14;
    localparam int ARG_FRAME_LEN = 4;

    logic [23:0] prefix_chars;
    logic [1:0]  prefix_len;
    int unsigned chars_in_frame;
    bit          prefix_ok;
    bit          digits_ok;
    logic [36:0] freq_acc;
    logic [7:0]  arg_char;
    result_t     pending_verdicts[$];
    int          mismatches;

    function new();
        prefix_chars = PREFIX_RESET;
        prefix_len   = PREFIX_LEN_RESET;
        mismatches   = 0;
        clear_frame();
    endfunction

    function void clear_frame();
        chars_in_frame = 0;
        prefix_ok      = 1'b1;
        digits_ok      = 1'b1;
        freq_acc       = '0;
        arg_char       = '0;
    endfunction

    function void set_reg(input logic [0:0] idx, input logic [23:0] data);
        if (cfg_reg_t'(idx) == REG_EXPECTED_PREFIX) begin
            prefix_chars = data;
        end else begin
            prefix_len = data[1:0];
        end
    endfunction

    function void note_char(input logic [7:0] c);
        result_t     r;
        int unsigned len;
        logic [15:0] pfx2;
        bit          two;
        bit          ok;
        if (c != CHAR_SEMI) begin
            // bytes past the frame limit are dropped
            if (chars_in_frame >= FRAME_LIMIT) begin
                return;
            end
            if (chars_in_frame < prefix_len) begin
                if (c != prefix_chars[8*chars_in_frame +: 8]) begin
                    prefix_ok = 1'b0;
                end
            end
            if (chars_in_frame == ARG_POS) begin
                arg_char = c;
            end
            if (chars_in_frame >= DIGIT_FIRST_POS && chars_in_frame <= DIGIT_LAST_POS) begin
                if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                    freq_acc = 37'(freq_acc * 10 + (c - CHAR_ZERO));
                end else begin
                    digits_ok = 1'b0;
                end
            end
            chars_in_frame++;
            return;
        end
        len = chars_in_frame + 1;
        r = '0;
        r.too_long = len > FRAME_LIMIT;
        r.frame_length = r.too_long ? 7'(FRAME_LIMIT) : 7'(len);
        ok = !r.too_long && prefix_ok && len >= prefix_len + 1;
        pfx2 = prefix_chars[15:0];
        two = prefix_len == 2;
        if (ok) begin
            if (two && (pfx2 == PFX_FA || pfx2 == PFX_FB)) begin
                ok = len == FREQ_FRAME_LEN && digits_ok;
                if (ok) begin
                    r.frequency_hz = freq_acc;
                end
            end else if (two && pfx2 == PFX_MD) begin
                ok = len == ARG_FRAME_LEN && arg_char >= CHAR_ONE && arg_char <= CHAR_NINE;
                if (ok) begin
                    r.mode_number = 4'(arg_char - CHAR_ZERO);
                end
            end else if (two && pfx2 == PFX_TQ) begin
                ok = len == ARG_FRAME_LEN && (arg_char == CHAR_ZERO || arg_char == CHAR_ONE);
                if (ok) begin
                    r.transmitting = arg_char == CHAR_ONE;
                end
            end else begin
                ok = len > prefix_len + 1;
            end
        end
        r.valid_res = ok;
        pending_verdicts.push_back(r);
        clear_frame();
    endfunction

    task report(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    task check_result(input result_t got);
        result_t want;
        if (pending_verdicts.size() == 0) begin
            report($sformatf("result transfer with no frame pending (len %0d)",
                             got.frame_length));
            return;
        end
        want = pending_verdicts.pop_front();
        if (got.valid_res !== want.valid_res)
            report($sformatf("valid_res got %0d exp %0d", got.valid_res, want.valid_res));
        if (got.frequency_hz !== want.frequency_hz)
            report($sformatf("frequency_hz got %0d exp %0d",
                             got.frequency_hz, want.frequency_hz));
        if (got.mode_number !== want.mode_number)
            report($sformatf("mode_number got %0d exp %0d",
                             got.mode_number, want.mode_number));
        if (got.transmitting !== want.transmitting)
            report($sformatf("transmitting got %0d exp %0d",
                             got.transmitting, want.transmitting));
        if (got.frame_length !== want.frame_length)
            report($sformatf("frame_length got %0d exp %0d",
                             got.frame_length, want.frame_length));
        if (got.too_long !== want.too_long)
            report($sformatf("too_long got %0d exp %0d", got.too_long, want.too_long));
    endtask

    task check_drained();
        if (pending_verdicts.size() != 0) begin
            report($sformatf("%0d frame results never arrived", pending_verdicts.size()));
        end
    endtask
endclass

module cat_response_frame_checker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_LIMIT = MAX_FRAME_DEFAULT;
    localparam int CHARS_PER_PHASE = 110;
    localparam int NUM_PHASES = 10;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_character = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_valid_res;
    logic [36:0] m_frequency_hz;
    logic [3:0]  m_mode_number;
    logic        m_transmitting;
    logic [6:0]  m_frame_length;
    logic        m_too_long;
    logic        cfg_wr_en = 1'b0;
    logic [0:0]  cfg_addr = '0;
    logic [23:0] cfg_wdata = '0;
    result_t     seen_result;

    frame_verdicts sb = new();

    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          rx_hold_cycles = 0;
    int          chars_sent = 0;
    logic [23:0] cur_prefix = PREFIX_RESET;
    logic [1:0]  cur_len = PREFIX_LEN_RESET;
    int          tx_idle_by_mode[4] = '{0, 66, 0, 13};
    int          rx_stall_by_mode[4] = '{0, 0, 66, 13};

    cat_response_frame_checker_top #(
        .MAX_FRAME(FRAME_LIMIT)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_character(s_character),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_valid_res(m_valid_res),
        .m_frequency_hz(m_frequency_hz),
        .m_mode_number(m_mode_number),
        .m_transmitting(m_transmitting),
        .m_frame_length(m_frame_length),
        .m_too_long(m_too_long),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    assign seen_result = {m_valid_res, m_frequency_hz, m_mode_number, m_transmitting,
                          m_frame_length, m_too_long};

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (rx_hold_cycles > 0) begin
            m_ready <= 1'b0;
            rx_hold_cycles--;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_char(s_character);
            if (m_valid && m_ready) sb.check_result(seen_result);
            if (cfg_wr_en) sb.set_reg(cfg_addr, cfg_wdata);
        end
    end

    initial begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [7:0] any_but_semi();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (c == CHAR_SEMI);
        return c;
    endfunction

    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_character <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_char(s[k]);
    endtask

    // wait until every frame result is out
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_verdicts.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(input logic [23:0] prefix, input logic [1:0] len);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_EXPECTED_PREFIX;
        cfg_wdata <= prefix;
        @(posedge aclk);
        cfg_addr  <= REG_PREFIX_LENGTH;
        cfg_wdata <= {22'd0, len};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_prefix = prefix;
        cur_len = len;
    endtask

    task automatic send_random_frame();
        logic [7:0]  frame[$];
        int unsigned pick;
        int unsigned n;
        logic [15:0] pfx2;
        pick = $urandom_range(99);
        pfx2 = cur_prefix[15:0];
        if (pick < 8) begin
            // raw noise, may end mid-frame
            n = $urandom_range(1, 12);
            repeat (n) frame.push_back(8'($urandom_range(255)));
        end else if (pick < 10) begin
            // around and beyond the frame limit
            n = $urandom_range(FRAME_LIMIT - 3, FRAME_LIMIT + 6);
            repeat (n) frame.push_back(any_but_semi());
            frame.push_back(CHAR_SEMI);
        end else begin
            for (int k = 0; k < cur_len; k++) frame.push_back(cur_prefix[8*k +: 8]);
            if (pick < 20 && frame.size() > 0) begin
                frame[$urandom_range(frame.size() - 1)] = 8'($urandom_range(255));
            end
            if (cur_len == 2 && (pfx2 == PFX_FA || pfx2 == PFX_FB)) begin
                n = ($urandom_range(7) == 0) ? $urandom_range(0, 13) : 11;
                repeat (n) begin
                    frame.push_back(($urandom_range(15) == 0) ? any_but_semi()
                                    : 8'(CHAR_ZERO + $urandom_range(9)));
                end
            end else if (cur_len == 2 && (pfx2 == PFX_MD || pfx2 == PFX_TQ)) begin
                n = ($urandom_range(7) == 0) ? $urandom_range(0, 3) : 1;
                repeat (n) begin
                    frame.push_back(($urandom_range(7) == 0) ? any_but_semi()
                                    : 8'(CHAR_ZERO + $urandom_range(pfx2 == PFX_TQ ? 1 : 9)));
                end
            end else begin
                n = $urandom_range(0, 6);
                repeat (n) frame.push_back(any_but_semi());
            end
            frame.push_back(CHAR_SEMI);
        end
        foreach (frame[k]) send_char(frame[k]);
    endtask

    initial begin
        int phase_start;
        logic [23:0] prefix;
        logic [1:0]  len;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed opener
        send_text("FA99999999999;");
        send_text("FA00000000000;");
        settle();
        configure({8'h00, PFX_MD}, 2);
        send_text("MD9;MD0;");
        settle();
        configure({8'h00, PFX_TQ}, 2);
        send_text("TQ1;TQ0;");
        settle();
        configure(24'h000000, 0);
        send_text(";");
        send_char(8'h00);
        send_char(8'hFF);
        send_char(CHAR_SEMI);
        settle();
        configure({8'h00, PFX_FA}, 2);
        send_text("F");
        settle();
        configure({8'h00, PFX_FB}, 2);
        send_text("B12345678901;");
        repeat (FRAME_LIMIT + 6) send_char(any_but_semi());
        send_char(CHAR_SEMI);
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin prefix = {8'h00, PFX_FA};     len = 2; end
                1: begin prefix = {8'h00, PFX_FB};     len = 2; end
                2: begin prefix = {8'h00, PFX_MD};     len = 2; end
                3: begin prefix = {8'h00, PFX_TQ};     len = 2; end
                4: begin prefix = 24'h000000;          len = 0; end
                5: begin prefix = 24'hFFFFFF;          len = 3; end
                6: begin prefix = 24'($urandom);       len = 1; end
                7: begin prefix = 24'($urandom);       len = 2'($urandom_range(3)); end
                8: begin prefix = {8'hFF, PFX_FA};     len = 2; end
                default: begin prefix = {8'h3F, PFX_MD}; len = 3; end
            endcase
            configure(prefix, len);
            tx_idle_pct = tx_idle_by_mode[p % 4];
            rx_stall_pct = rx_stall_by_mode[p % 4];
            if (p == 2) rx_hold_cycles = 300;
            phase_start = chars_sent;
            while (chars_sent - phase_start < CHARS_PER_PHASE) begin
                send_random_frame();
                if (p == 5 && chars_sent - phase_start >= CHARS_PER_PHASE / 2
                    && chars_sent - phase_start < CHARS_PER_PHASE / 2 + 12) begin
                    s_valid <= 1'b0;
                    @(posedge aclk);
                    while (sb.pending_verdicts.size() != 0) @(posedge aclk);
                end
            end
            settle();
        end

        repeat (8) @(posedge aclk);
        sb.check_drained();
        if (sb.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
